// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL; clock clk, asynchronous reset arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/gpcd_pkg.sv =====
// ----------------------------------------------------------------------------
// gpcd_pkg
// Types, constants and the erf knot table for the Gaussian cell deposit block.
// ----------------------------------------------------------------------------
`default_nettype none

package gpcd_pkg;

	localparam int ERF_SEGMENTS = 64;
	localparam int SEG_LOG      = $clog2(ERF_SEGMENTS);
	localparam int ARG_FRAC     = 20;
	localparam int ARG_W        = ARG_FRAC + 3;
	localparam int IDX_SH       = ARG_FRAC + 2 - SEG_LOG;
	localparam int IDX_W        = ARG_W - IDX_SH;
	localparam int FRAC_W       = ARG_FRAC + 2;
	localparam int KNOT_W       = 31;
	localparam int SERIES_TERMS = 128;
	localparam logic [28:0] SQRT2_Q28 = 29'd379625062;
	localparam logic [63:0] TWO_OVER_SQRTPI_Q30 = 64'd1211587905;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [47:0] MAX48 = '1;
	localparam logic [23:0] MAX24 = '1;

	// configuration register indexes
	localparam logic [2:0] REG_X_LOW  = 3'd0;
	localparam logic [2:0] REG_Z_HIGH = 3'd5;

	typedef struct packed {
		logic signed [31:0] centre_x;
		logic signed [31:0] centre_y;
		logic signed [31:0] centre_z;
		logic [31:0]        spread;
		logic [31:0]        weight;
		logic               final_particle;
	} particle_t;

	typedef struct packed {
		logic [47:0] cell_total;
		logic [23:0] hit_count;
		logic        saturated;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_TEST, ST_DEN, ST_SETUP, ST_DIV, ST_LOOK, ST_MUL, ST_EVAL,
		ST_P1, ST_P2, ST_P3, ST_ACC, ST_FIN
	} state_t;

	typedef logic [KNOT_W-1:0] knot_tab_t [0:ERF_SEGMENTS];

	// exact unsigned quotient by shift and subtract, elaboration use only
	function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
		logic [63:0] q, r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			if (r >= den) begin
				r    = r - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Erf knots in Q1.30, evaluated at elaboration
	function automatic knot_tab_t build_knots();
		knot_tab_t tab;
		logic [63:0] xq, x2, u, p, c, s, e;
		for (int k = 0; k <= ERF_SEGMENTS; k++) begin
			xq = (64'(k) << 26) / ERF_SEGMENTS;
			x2 = (xq * xq) >> 24;
			u  = x2 >> 2;
			p  = Q30_ONE - u / 5;
			p  = Q30_ONE - ((u * p) >> 30) / 4;
			p  = Q30_ONE - ((u * p) >> 30) / 3;
			p  = Q30_ONE - ((u * p) >> 30) / 2;
			p  = Q30_ONE - ((u * p) >> 30);
			for (int i = 0; i < 8; i++) begin
				p = (p * p) >> 30;
			end
			c = ((xq << 6) * p) >> 30;
			s = '0;
			for (int n = 0; n < SERIES_TERMS; n++) begin
				s = s + c;
				c = udiv64((c * (x2 << 1)) >> 24, 64'(2 * n + 3));
			end
			e = (s * TWO_OVER_SQRTPI_Q30) >> 30;
			tab[k] = (e > Q30_ONE) ? KNOT_W'(Q30_ONE) : KNOT_W'(e);
		end
		return tab;
	endfunction

	localparam knot_tab_t ERF_TAB = build_knots();

endpackage

`default_nettype wire

// ===== design/gaussian_particle_cell_deposit.sv =====
// Gaussian particle cell deposit. Six registers hold one cell's box; each
// particle request is tested against the box widened by three sigma and, if
// inside, adds |dX*dY*dZ|/8 * mass to a saturating total and bumps a hit
// count. The request marked final returns the sums and clears them. One
// shared multiplier and one 64-bit subtract/compare unit do all the work
// under a sequencer: a particle outside the box or with zero sigma goes
// from the box test straight to the finish step, while a contributing
// particle runs six bit-serial erf argument divisions (23 steps each; an
// argument of four or more ends its division after one step). The
// particle side is stalled while a particle is in work; a final request
// also waits while the previous result is still unread. A finished result
// waits in an output register while the next particle is accepted.
`default_nettype none
`include "assert_macros.svh"

module gaussian_particle_cell_deposit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 particle_valid,
	output logic                      particle_stall,
	input  wire gpcd_pkg::particle_t  particle,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output gpcd_pkg::result_t         result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [31:0]          cfg_data
);

	gpcd_pkg::state_t state_q, state_d;

	logic signed [31:0]                 box_q [0:5];
	gpcd_pkg::particle_t                item_q;
	logic [60:0]                        den_q;
	logic [1:0]                         axis_q;
	logic                               upper_q;
	logic [4:0]                         cnt_q;
	logic [63:0]                        r_q;
	logic [gpcd_pkg::ARG_W-1:0]         t_q;
	logic                               neg_q;
	logic [gpcd_pkg::KNOT_W-1:0]        lo_q;
	logic [gpcd_pkg::KNOT_W-1:0]        delta_q;
	logic [gpcd_pkg::FRAC_W-1:0]        frac_q;
	logic signed [31:0]                 ehi_q;
	logic [31:0]                        ax_q, ay_q, az_q;
	logic [47:0]                        total_q;
	logic [23:0]                        hits_q;
	logic                               ovf_q;
	logic                               result_valid_q;
	gpcd_pkg::result_t                  result_q;

	logic [32:0]                        mul_a;
	logic [31:0]                        mul_b;
	logic [64:0]                        mul_q;

	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) box_q[i] <= '0;
		end else if (cfg_valid && cfg_ready && cfg_index <= gpcd_pkg::REG_Z_HIGH) begin
			box_q[cfg_index - gpcd_pkg::REG_X_LOW] <= cfg_data;
		end
	end

	// box test against the widened bounds
	logic signed [35:0] reach;
	logic               in_x, in_y, in_z, hit;
	always_comb begin
		reach = 36'(item_q.spread) * 36'sd3;
		in_x  = (36'(item_q.centre_x) < 36'(box_q[1]) + reach)
			&& (36'(item_q.centre_x) > 36'(box_q[0]) - reach);
		in_y  = (36'(item_q.centre_y) < 36'(box_q[3]) + reach)
			&& (36'(item_q.centre_y) > 36'(box_q[2]) - reach);
		in_z  = (36'(item_q.centre_z) < 36'(box_q[5]) + reach)
			&& (36'(item_q.centre_z) > 36'(box_q[4]) - reach);
		hit   = (item_q.spread != '0) && in_x && in_y && in_z;
	end

	// bound minus centre for the current axis and bound
	logic signed [31:0] bound_v, centre_v;
	logic signed [32:0] bdiff;
	logic [31:0]        mag;
	always_comb begin
		bound_v  = box_q[{axis_q, upper_q}];
		case (axis_q)
			2'd0:    centre_v = item_q.centre_x;
			2'd1:    centre_v = item_q.centre_y;
			default: centre_v = item_q.centre_z;
		endcase
		bdiff = 33'(bound_v) - 33'(centre_v);
		mag   = bdiff[32] ? 32'(-bdiff) : 32'(bdiff);
	end

	// divider step: shared subtract/compare
	logic [63:0] div_a, div_b;
	logic        div_ge;
	always_comb begin
		div_a  = (cnt_q >= 5'd3) ? {r_q[62:0], 1'b0} : r_q;
		case (cnt_q)
			5'd0:    div_b = {1'b0, den_q, 2'b00};
			5'd1:    div_b = {2'b00, den_q, 1'b0};
			default: div_b = {3'b000, den_q};
		endcase
		div_ge = div_a >= div_b;
	end

	// knot lookup
	logic [gpcd_pkg::IDX_W-1:0]  idx;
	logic [gpcd_pkg::KNOT_W-1:0] k_lo, k_hi;
	always_comb begin
		idx  = t_q[gpcd_pkg::ARG_W-1:gpcd_pkg::IDX_SH];
		k_lo = gpcd_pkg::ERF_TAB[gpcd_pkg::ERF_SEGMENTS];
		k_hi = k_lo;
		if (idx < gpcd_pkg::IDX_W'(gpcd_pkg::ERF_SEGMENTS)) begin
			k_lo = gpcd_pkg::ERF_TAB[idx];
			k_hi = gpcd_pkg::ERF_TAB[idx + 1'b1];
		end
	end

	// interpolated erf and axis difference
	logic [gpcd_pkg::KNOT_W-1:0] erf_mag;
	logic signed [31:0]          erf_val;
	logic signed [32:0]          ediff;
	always_comb begin
		erf_mag = lo_q + gpcd_pkg::KNOT_W'(mul_q >> gpcd_pkg::FRAC_W);
		erf_val = neg_q ? -32'(erf_mag) : 32'(erf_mag);
		ediff   = 33'(ehi_q) - 33'(erf_val);
	end

	// accumulation
	logic [48:0] sum;
	always_comb begin
		sum = {1'b0, total_q} + 49'(mul_q[64:30]);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gpcd_pkg::ST_IDLE:  if (particle_valid) state_d = gpcd_pkg::ST_TEST;
			gpcd_pkg::ST_TEST:  state_d = hit ? gpcd_pkg::ST_DEN : gpcd_pkg::ST_FIN;
			gpcd_pkg::ST_DEN:   state_d = gpcd_pkg::ST_SETUP;
			gpcd_pkg::ST_SETUP: state_d = gpcd_pkg::ST_DIV;
			gpcd_pkg::ST_DIV: begin
				if ((cnt_q == 5'd0 && div_ge) || cnt_q == 5'd22) state_d = gpcd_pkg::ST_LOOK;
			end
			gpcd_pkg::ST_LOOK:  state_d = gpcd_pkg::ST_MUL;
			gpcd_pkg::ST_MUL:   state_d = gpcd_pkg::ST_EVAL;
			gpcd_pkg::ST_EVAL: begin
				state_d = (!upper_q && axis_q == 2'd2) ? gpcd_pkg::ST_P1 : gpcd_pkg::ST_SETUP;
			end
			gpcd_pkg::ST_P1:    state_d = gpcd_pkg::ST_P2;
			gpcd_pkg::ST_P2:    state_d = gpcd_pkg::ST_P3;
			gpcd_pkg::ST_P3:    state_d = gpcd_pkg::ST_ACC;
			gpcd_pkg::ST_ACC:   state_d = gpcd_pkg::ST_FIN;
			gpcd_pkg::ST_FIN: begin
				if (!item_q.final_particle || !result_valid_q || !result_stall)
					state_d = gpcd_pkg::ST_IDLE;
			end
			default:            state_d = gpcd_pkg::ST_IDLE;
		endcase
	end

	// outputs: handshake and multiplier operands
	always_comb begin
		particle_stall = (state_q != gpcd_pkg::ST_IDLE);
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			gpcd_pkg::ST_TEST: begin
				mul_a = 33'(item_q.spread);
				mul_b = 32'(gpcd_pkg::SQRT2_Q28);
			end
			gpcd_pkg::ST_MUL: begin
				mul_a = 33'(delta_q);
				mul_b = 32'(frac_q);
			end
			gpcd_pkg::ST_P1: begin
				mul_a = 33'(ax_q);
				mul_b = ay_q;
			end
			gpcd_pkg::ST_P2: begin
				mul_a = mul_q[62:30];
				mul_b = az_q;
			end
			gpcd_pkg::ST_P3: begin
				mul_a = {1'b0, mul_q[64:33]};
				mul_b = item_q.weight;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// shared multiplier
	always_ff @(posedge clk) begin
		mul_q <= 65'(mul_a) * 65'(mul_b);
	end

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= gpcd_pkg::ST_IDLE;
			axis_q         <= '0;
			upper_q        <= 1'b1;
			cnt_q          <= '0;
			total_q        <= '0;
			hits_q         <= '0;
			ovf_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// result register: loaded by a final request, freed when read
			if (state_q == gpcd_pkg::ST_FIN && item_q.final_particle
				&& (!result_valid_q || !result_stall))
				result_valid_q <= 1'b1;
			else if (result_valid_q && !result_stall)
				result_valid_q <= 1'b0;
			case (state_q)
				gpcd_pkg::ST_DEN: begin
					axis_q  <= '0;
					upper_q <= 1'b1;
				end
				gpcd_pkg::ST_SETUP: cnt_q <= '0;
				gpcd_pkg::ST_DIV:   cnt_q <= cnt_q + 5'd1;
				gpcd_pkg::ST_EVAL: begin
					upper_q <= !upper_q;
					if (!upper_q) axis_q <= axis_q + 2'd1;
				end
				gpcd_pkg::ST_ACC: begin
					total_q <= sum[48] ? gpcd_pkg::MAX48 : sum[47:0];
					if (hits_q != gpcd_pkg::MAX24) hits_q <= hits_q + 24'd1;
					ovf_q <= ovf_q || sum[48] || (hits_q == gpcd_pkg::MAX24);
				end
				gpcd_pkg::ST_FIN: begin
					if (item_q.final_particle && (!result_valid_q || !result_stall)) begin
						total_q        <= '0;
						hits_q         <= '0;
						ovf_q          <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			gpcd_pkg::ST_IDLE: if (particle_valid) item_q <= particle;
			gpcd_pkg::ST_DEN:  den_q <= mul_q[60:0];
			gpcd_pkg::ST_SETUP: begin
				r_q   <= {4'b0000, mag, 28'd0};
				neg_q <= bdiff[32];
				t_q   <= '0;
			end
			gpcd_pkg::ST_DIV: begin
				if (cnt_q == 5'd0) begin
					if (div_ge) t_q <= gpcd_pkg::ARG_W'(4) << gpcd_pkg::ARG_FRAC;
				end else begin
					r_q <= div_ge ? div_a - div_b : div_a;
					t_q <= {t_q[gpcd_pkg::ARG_W-2:0], div_ge};
				end
			end
			gpcd_pkg::ST_LOOK: begin
				lo_q    <= k_lo;
				delta_q <= (k_hi > k_lo) ? k_hi - k_lo : '0;
				frac_q  <= {t_q[gpcd_pkg::IDX_SH-1:0], {gpcd_pkg::SEG_LOG{1'b0}}};
			end
			gpcd_pkg::ST_EVAL: begin
				if (upper_q) begin
					ehi_q <= erf_val;
				end else begin
					case (axis_q)
						2'd0:    ax_q <= ediff[32] ? 32'(-ediff) : 32'(ediff);
						2'd1:    ay_q <= ediff[32] ? 32'(-ediff) : 32'(ediff);
						default: az_q <= ediff[32] ? 32'(-ediff) : 32'(ediff);
					endcase
				end
			end
			gpcd_pkg::ST_FIN: begin
				if (item_q.final_particle && (!result_valid_q || !result_stall)) begin
					result_q.cell_total <= total_q;
					result_q.hit_count  <= hits_q;
					result_q.saturated  <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	`ASSERT_NEXT(a_stall_after_accept, particle_valid && !particle_stall, particle_stall,
		"particle accepted but not stalled next cycle")
	`ASSERT_NEXT(a_result_from_fin, !result_valid && state_q != gpcd_pkg::ST_FIN,
		!result_valid, "result raised outside the finish step")
	`ASSERT_SAME(a_div_bound, state_q == gpcd_pkg::ST_DIV, cnt_q <= 5'd22,
		"divider step count overran")
	`ASSERT_SAME(a_arg_range, state_q == gpcd_pkg::ST_LOOK,
		t_q <= (gpcd_pkg::ARG_W'(4) << gpcd_pkg::ARG_FRAC), "erf argument above four")

endmodule

`default_nettype wire

// ===== tb/gaussian_particle_cell_deposit_tb.sv =====
// ----------------------------------------------------------------------------
// gaussian_particle_cell_deposit_tb
// Self-checking bench: drives particle requests in random bursts against a
// set of cell boxes, predicts each cell total, hit count and saturation flag
// with a local fixed-point model and compares every result request.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_particle_cell_deposit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1300;
	localparam int IDLE_LIMIT   = 6000;
	localparam int SETTLE       = 250;
	localparam logic [63:0] ROOT2_Q28 = 64'd379625062;

	typedef enum logic [2:0] {
		IDX_X_LOW, IDX_X_HIGH, IDX_Y_LOW, IDX_Y_HIGH, IDX_Z_LOW, IDX_Z_HIGH,
		IDX_SPARE_A, IDX_SPARE_B
	} box_idx_t;

	typedef enum int {BOX_KEEP, BOX_UNIT, BOX_INVERTED, BOX_EXTREME} box_pick_t;

	typedef struct {
		box_pick_t           box;
		gpcd_pkg::particle_t p;
		bit                  typed;
		gpcd_pkg::result_t   r;
	} stim_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      particle_valid = 1'b0;
	logic      particle_stall;
	gpcd_pkg::particle_t particle = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	gpcd_pkg::result_t   result;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// predictor state
	logic [63:0] erf_knot [0:64];
	logic signed [31:0] box_reg [0:5];
	logic [47:0] acc_total;
	logic [23:0] acc_hits;
	logic        acc_over;

	gpcd_pkg::result_t pending_totals [$];
	bit                typed_flag_q [$];
	gpcd_pkg::result_t typed_value_q [$];

	int mismatches = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	bit hold_go = 1'b0;

	gaussian_particle_cell_deposit dut (
		.clk(clk), .arst_n(arst_n),
		.particle_valid(particle_valid), .particle_stall(particle_stall),
		.particle(particle),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// erf knots, Q1.30, from the series recipe
	function automatic void fill_knots();
		logic [63:0] xq, x2, u, p, c, s, e;
		for (int k = 0; k <= 64; k++) begin
			xq = (64'(k) << 26) / 64;
			x2 = (xq * xq) >> 24;
			u  = x2 >> 2;
			p  = (64'd1 << 30) - u / 5;
			p  = (64'd1 << 30) - ((u * p) >> 30) / 4;
			p  = (64'd1 << 30) - ((u * p) >> 30) / 3;
			p  = (64'd1 << 30) - ((u * p) >> 30) / 2;
			p  = (64'd1 << 30) - ((u * p) >> 30);
			for (int i = 0; i < 8; i++) p = (p * p) >> 30;
			c = ((xq << 6) * p) >> 30;
			s = 0;
			for (int n = 0; n < 128; n++) begin
				s = s + c;
				c = ((c * (x2 << 1)) >> 24) / 64'(2 * n + 3);
			end
			e = (s * 64'd1211587905) >> 30;
			erf_knot[k] = (e > (64'd1 << 30)) ? (64'd1 << 30) : e;
		end
	endfunction

	// interpolated erf of a Q3.20 argument
	function automatic logic [63:0] erf_interp(logic [63:0] t);
		logic [63:0] scaled, seg, frac, lo, hi;
		scaled = t * 64;
		seg = scaled >> 22;
		frac = scaled & ((64'd1 << 22) - 1);
		if (seg >= 64) return erf_knot[64];
		lo = erf_knot[seg];
		hi = erf_knot[seg + 1];
		if (hi <= lo) return lo;
		return lo + (((hi - lo) * frac) >> 22);
	endfunction

	// signed erf(d / (sigma*sqrt2)) via bit-serial fractional divide
	function automatic longint erf_signed(longint d, logic [63:0] den);
		logic [63:0] mag, num, t, q, r;
		longint v;
		mag = (d < 0) ? 64'(-d) : 64'(d);
		num = mag << 28;
		if (num >= 4 * den) begin
			t = 64'd4 << 20;
		end else begin
			q = num / den;
			r = num - q * den;
			t = q;
			for (int i = 0; i < 20; i++) begin
				r = r << 1;
				t = t << 1;
				if (r >= den) begin
					r = r - den;
					t = t | 64'd1;
				end
			end
		end
		v = longint'(erf_interp(t));
		return (d < 0) ? -v : v;
	endfunction

	function automatic logic [63:0] axis_span(int a, longint c, logic [63:0] den);
		longint diff;
		diff = erf_signed(longint'(box_reg[a + 1]) - c, den)
			- erf_signed(longint'(box_reg[a]) - c, den);
		return (diff < 0) ? 64'(-diff) : 64'(diff);
	endfunction

	function automatic bit within_reach(int a, longint c, longint reach);
		return c < longint'(box_reg[a + 1]) + reach && c > longint'(box_reg[a]) - reach;
	endfunction

	// advance the cell sums by one particle; returns 1 when a result is due
	function automatic bit deposit_predict(gpcd_pkg::particle_t p,
		output gpcd_pkg::result_t r);
		longint reach;
		logic [63:0] den, ax, ay, az, prod, share, sum;
		if (p.spread != 0) begin
			reach = 3 * longint'(p.spread);
			if (within_reach(0, longint'(p.centre_x), reach) &&
				within_reach(2, longint'(p.centre_y), reach) &&
				within_reach(4, longint'(p.centre_z), reach)) begin
				den = 64'(p.spread) * ROOT2_Q28;
				ax = axis_span(0, longint'(p.centre_x), den);
				ay = axis_span(2, longint'(p.centre_y), den);
				az = axis_span(4, longint'(p.centre_z), den);
				prod = (ax * ay) >> 30;
				prod = ((prod * az) >> 30) >> 3;
				share = (prod * 64'(p.weight)) >> 30;
				sum = 64'(acc_total) + share;
				if (sum > 64'(gpcd_pkg::MAX48)) begin
					acc_total = gpcd_pkg::MAX48;
					acc_over = 1'b1;
				end else begin
					acc_total = sum[47:0];
				end
				if (acc_hits == gpcd_pkg::MAX24) acc_over = 1'b1;
				else acc_hits = acc_hits + 1;
			end
		end
		r = '{cell_total: acc_total, hit_count: acc_hits, saturated: acc_over};
		if (!p.final_particle) return 1'b0;
		acc_total = '0;
		acc_hits = '0;
		acc_over = 1'b0;
		return 1'b1;
	endfunction

	// particle acceptance: predict and queue the expected result
	always @(posedge clk) begin
		gpcd_pkg::result_t r;
		bit due;
		bit tf;
		gpcd_pkg::result_t tv;
		if (arst_n && particle_valid && !particle_stall) begin
			tf = typed_flag_q.pop_front();
			tv = typed_value_q.pop_front();
			due = deposit_predict(particle, r);
			if (due) pending_totals.push_back(tf ? tv : r);
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		gpcd_pkg::result_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_totals.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: total %h hits %h sat %b",
						result.cell_total, result.hit_count, result.saturated);
			end else begin
				e = pending_totals.pop_front();
				if (result.cell_total !== e.cell_total || result.hit_count !== e.hit_count ||
					result.saturated !== e.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp total %h hits %h sat %b, got %h %h %b",
							e.cell_total, e.hit_count, e.saturated,
							result.cell_total, result.hit_count, result.saturated);
				end
			end
		end
	end

	// receiver stall pattern, with an occasional long hold-off
	always @(posedge clk) begin
		static int hold_left = 0;
		static int mode = 0;
		static int mode_left = 0;
		if (hold_go) begin
			hold_go = 1'b0;
			hold_left = 900;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 300);
			end
			mode_left--;
			case (mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 1) == 0);
				2: result_stall <= ($urandom_range(0, 9) != 0);
				default: result_stall <= ((mode_left % 16) < 5);
			endcase
		end
	end

	// watchdog on accepted traffic
	always @(posedge clk) begin
		if ((particle_valid && !particle_stall) || (result_valid && !result_stall) ||
			(cfg_valid && cfg_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic quiet_sender();
		particle_valid <= 1'b0;
		burst_left = 0;
	endtask

	task automatic send_particle(gpcd_pkg::particle_t p, bit typed, gpcd_pkg::result_t r);
		int gap;
		typed_flag_q.push_back(typed);
		typed_value_q.push_back(r);
		particle_valid <= 1'b1;
		particle <= p;
		do @(posedge clk); while (!(particle_valid && !particle_stall));
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				particle_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// wait until the block has returned everything, then let it settle
	task automatic drain();
		quiet_sender();
		while (pending_totals.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(box_idx_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		if (idx <= IDX_Z_HIGH) box_reg[idx] = val;
	endtask

	task automatic load_box(logic signed [31:0] b [0:5]);
		drain();
		for (int i = 0; i < 6; i++) cfg_write(box_idx_t'(i), b[i]);
		if ($urandom_range(0, 7) == 0)
			cfg_write($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B, $urandom);
		cfg_valid <= 1'b0;
	endtask

	function automatic gpcd_pkg::particle_t mk(longint x, longint y, longint z, longint s,
		longint w, bit last);
		gpcd_pkg::particle_t p;
		p.centre_x = x[31:0];
		p.centre_y = y[31:0];
		p.centre_z = z[31:0];
		p.spread = s[31:0];
		p.weight = w[31:0];
		p.final_particle = last;
		return p;
	endfunction

	// a particle placed near the current box, with mostly moderate sigma
	function automatic gpcd_pkg::particle_t near_particle(bit last);
		longint c [0:2];
		longint s, span;
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) s = 0;
		else if (pick == 1) s = $urandom;
		else if (pick < 5) s = $urandom_range(1, 4096);
		else s = $urandom_range(1 << 12, 20 << 16);
		for (int a = 0; a < 3; a++) begin
			span = longint'(box_reg[2 * a + 1]) - longint'(box_reg[2 * a]);
			if (span < 0) span = -span;
			span = span + 3 * s + 1;
			if (span > 64'h7fff_ffff) span = 64'h7fff_ffff;
			c[a] = (longint'(box_reg[2 * a]) + longint'(box_reg[2 * a + 1])) / 2
				+ longint'($urandom_range(0, 2 * span)) - span;
		end
		return mk(c[0], c[1], c[2], s, $urandom, last);
	endfunction

	stim_row_t rows [$];

	initial begin
		logic signed [31:0] b [0:5];
		gpcd_pkg::result_t none;
		box_pick_t cur;
		gpcd_pkg::particle_t p;
		int cell_left;
		int sent;

		fill_knots();
		for (int i = 0; i < 6; i++) box_reg[i] = '0;
		acc_total = '0;
		acc_hits = '0;
		acc_over = 1'b0;
		none = '0;

		// directed rows; typed expectations hold for the reset (all-zero) box
		rows.push_back('{BOX_KEEP, mk(0, 0, 0, 0, 64'hffff_ffff, 1), 1,
			'{cell_total: 0, hit_count: 0, saturated: 0}});
		rows.push_back('{BOX_KEEP, mk(0, 0, 0, 1, 64'hffff_ffff, 0), 0, none});
		rows.push_back('{BOX_KEEP, mk(32'h7fff_ffff, -64'sh8000_0000, 0, 1, 0, 1), 1,
			'{cell_total: 0, hit_count: 1, saturated: 0}});
		rows.push_back('{BOX_KEEP, mk(-64'sh8000_0000, 32'h7fff_ffff, 0, 64'hffff_ffff, 0, 1),
			0, none});
		rows.push_back('{BOX_UNIT, mk(5 << 16, 5 << 16, 5 << 16, 1 << 16, 1 << 16, 0), 0, none});
		rows.push_back('{BOX_UNIT, mk(5 << 16, 5 << 16, 5 << 16, 64'hffff_ffff,
			64'hffff_ffff, 0), 0, none});
		rows.push_back('{BOX_UNIT, mk(-(3 << 16), 5 << 16, 5 << 16, 1 << 16, 1 << 16, 0), 0,
			none});
		rows.push_back('{BOX_UNIT, mk(-(3 << 16) + 1, 5 << 16, 5 << 16, 1 << 16,
			64'hffff_ffff, 0), 0, none});
		rows.push_back('{BOX_UNIT, mk(5 << 16, (13 << 16) - 1, 5 << 16, 1 << 16, 1 << 16, 0),
			0, none});
		rows.push_back('{BOX_UNIT, mk(5 << 16, 5 << 16, 1, 1, 64'hffff_ffff, 0), 0, none});
		rows.push_back('{BOX_UNIT, mk(5 << 16, 5 << 16, 5 << 16, 0, 64'hffff_ffff, 1), 0, none});
		rows.push_back('{BOX_INVERTED, mk(5 << 16, 5 << 16, 5 << 16, 2 << 16, 1 << 20, 0), 0,
			none});
		rows.push_back('{BOX_INVERTED, mk(-(4 << 16), 6 << 16, 0, 3 << 16, 64'hffff_ffff, 0), 0,
			none});
		rows.push_back('{BOX_INVERTED, mk(1, 2, 3, 64'hffff_ffff, 64'hffff_ffff, 1), 0, none});
		rows.push_back('{BOX_EXTREME, mk(0, 0, 0, 64'hffff_ffff, 64'hffff_ffff, 0), 0, none});
		rows.push_back('{BOX_EXTREME, mk(32'h7fff_ffff, -64'sh8000_0000, 1, 64'hffff_ffff,
			64'hffff_ffff, 0), 0, none});
		rows.push_back('{BOX_EXTREME, mk(0, 0, 0, 1, 64'hffff_ffff, 0), 0, none});
		rows.push_back('{BOX_EXTREME, mk(12345, -777, 99, 1 << 16, 1 << 16, 1), 0, none});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur = BOX_KEEP;
		foreach (rows[i]) begin
			if (rows[i].box != BOX_KEEP && rows[i].box != cur) begin
				cur = rows[i].box;
				case (cur)
					BOX_UNIT: b = '{0, 10 << 16, 0, 10 << 16, 0, 10 << 16};
					BOX_INVERTED: b = '{8 << 16, 2 << 16, 8 << 16, 2 << 16, 8 << 16, 2 << 16};
					default: b = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
						32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff};
				endcase
				load_box(b);
			end
			send_particle(rows[i].p, rows[i].typed, rows[i].r);
		end

		// random cells; mostly particles near the box, some raw noise
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: for (int i = 0; i < 6; i++) b[i] = $urandom;
				1: begin
					for (int i = 0; i < 6; i += 2) begin
						b[i] = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
						b[i + 1] = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
					end
				end
				default: begin
					for (int i = 0; i < 6; i += 2) begin
						b[i] = 32'($urandom_range(0, 2000 << 16)) - (1000 << 16);
						b[i + 1] = b[i] + 32'($urandom_range(0, 50 << 16))
							- ($urandom_range(0, 9) == 0 ? (60 << 16) : 0);
					end
				end
			endcase
			load_box(b);
			if ($urandom_range(0, 3) == 0) drain();
			if (sent >= 300 && sent < 340) begin
				hold_go = 1'b1;
				for (int i = 0; i < 30; i++) begin
					p = near_particle(i % 2);
					send_particle(p, 0, none);
				end
				sent += 30;
			end
			cell_left = $urandom_range(1, 20);
			for (int i = 0; i < cell_left; i++) begin
				if ($urandom_range(0, 9) == 0)
					p = mk($urandom, $urandom, $urandom, $urandom, $urandom, 0);
				else
					p = near_particle(0);
				p.final_particle = (i == cell_left - 1);
				send_particle(p, 0, none);
			end
			sent += cell_left;
		end

		drain();
		if (mismatches == 0 && pending_totals.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
